/* hw/rtl/binomial_sampler_table_box_muller_core_macros.svh */
// assertion macros shared by the sampler rtl
`ifndef BINOMIAL_SAMPLER_TABLE_BOX_MULLER_CORE_MACROS_SVH
`define BINOMIAL_SAMPLER_TABLE_BOX_MULLER_CORE_MACROS_SVH

`ifndef SYNTH
`define BSBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define BSBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BSBM_ASSERT_NOW(label, ante, cons)
`define BSBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hw/rtl/bsbm_pkg.sv */
package bsbm_pkg;

    localparam int TABLE_ENTRIES  = 256;
    localparam int ADDR_W         = 8;
    localparam int DEF_COUNT_BITS = 16;

    localparam int RAND_W     = 16;
    localparam int TRIALS_W   = 16;
    localparam int PROB_W     = 17;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    localparam int RAD_W  = 16;
    localparam int CMAG_W = 15;
    localparam int ZMAG_W = RAD_W + CMAG_W;
    localparam int PQ_W   = 31;

    localparam logic [PROB_W-1:0] PROB_ONE   = 17'h10000;
    localparam logic [PROB_W-1:0] PROB_RESET = 17'h08000;

    localparam logic [CFG_IDX_W-1:0] REG_TRIALS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBABILITY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PQ,
        S_VAR,
        S_SQRT
    } t_cfg_state;

    typedef logic [TABLE_ENTRIES-1:0][RAD_W-1:0] t_rad_rom;
    typedef logic [TABLE_ENTRIES-1:0][CMAG_W:0]  t_ang_rom;

    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] DENOM   = 64'd257;

    // restoring divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = x;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] ln_int_q32(input logic [63:0] k);
        logic [63:0] m;
        logic [63:0] p2;
        logic [63:0] z;
        logic [63:0] zz;
        logic [63:0] t;
        logic [63:0] sum;
        m  = '0;
        p2 = 64'd1;
        for (int j = 0; j < 21; j++) begin
            if (p2 * 64'd2 <= k) begin
                p2 = p2 * 64'd2;
                m  = m + 64'd1;
            end
        end
        z   = udiv64((k - p2) << 32, k + p2);
        zz  = (z * z) >> 32;
        t   = z;
        sum = z;
        for (int j = 1; j < 16; j++) begin
            t   = (t * zz) >> 32;
            sum = sum + udiv64(t, 64'(2 * j + 1));
        end
        return m * LN2_Q32 + 64'd2 * sum;
    endfunction

    function automatic logic [63:0] cos_q30(input logic [63:0] num);
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        tm;
        logic signed [63:0] sum;
        a   = udiv64(PI_Q30 * num, DENOM);
        a2  = (a * a) >> 30;
        tm  = 64'd1 << 30;
        sum = signed'(tm);
        for (int j = 1; j <= 12; j++) begin
            tm = udiv64((tm * a2) >> 30, 64'((2 * j - 1) * (2 * j)));
            if ((j & 1) != 0) begin
                sum = sum - signed'(tm);
            end else begin
                sum = sum + signed'(tm);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    // sqrt(-2 ln((i+1)/257)) in q2.14
    function automatic t_rad_rom radius_rom();
        t_rad_rom    rom;
        logic [63:0] ln_top;
        logic [63:0] k;
        logic [63:0] v;
        logic [63:0] s;
        ln_top = ln_int_q32(DENOM);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            k      = 64'(i) + 64'd1;
            v      = 64'd2 * (ln_top - ln_int_q32(k));
            s      = isqrt64(v << 26);
            rom[i] = RAD_W'((s + (64'd1 << 14)) >> 15);
        end
        return rom;
    endfunction

    // cos(2 pi (i+1)/257) as sign and q1.14 magnitude
    function automatic t_ang_rom angle_rom();
        t_ang_rom    rom;
        logic [63:0] k;
        logic [63:0] kk;
        logic [63:0] num;
        logic [63:0] c;
        logic        neg;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            k   = 64'(i) + 64'd1;
            kk  = (k <= DENOM - k) ? k : DENOM - k;
            num = 64'd2 * kk;
            neg = 1'b0;
            if (64'd2 * num > DENOM) begin
                neg = 1'b1;
                num = DENOM - num;
            end
            c      = (cos_q30(num) + (64'd1 << 15)) >> 16;
            rom[i] = {neg && (c != 64'd0), CMAG_W'(c)};
        end
        return rom;
    endfunction

endpackage

/* hw/rtl/bsbm_rom.sv */
module bsbm_rom (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bsbm_pkg::ADDR_W-1:0]   i_rad_addr,
    input  logic [bsbm_pkg::ADDR_W-1:0]   i_ang_addr,
    output logic [bsbm_pkg::RAD_W-1:0]    o_rad,
    output logic [bsbm_pkg::CMAG_W-1:0]   o_cmag,
    output logic                          o_neg
);
    import bsbm_pkg::*;

    localparam t_rad_rom RAD_ROM = radius_rom();
    localparam t_ang_rom ANG_ROM = angle_rom();

    logic [RAD_W-1:0] r_rad;
    logic [CMAG_W:0]  r_ang;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= RAD_ROM[i_rad_addr];
            r_ang <= ANG_ROM[i_ang_addr];
        end
    end

    assign o_rad  = r_rad;
    assign o_cmag = r_ang[CMAG_W-1:0];
    assign o_neg  = r_ang[CMAG_W];

endmodule

/* hw/rtl/bsbm_cfg.sv */
`include "binomial_sampler_table_box_muller_core_macros.svh"

module bsbm_cfg #(
    parameter int  COUNT_BITS = bsbm_pkg::DEF_COUNT_BITS,
    localparam int N_W        = (COUNT_BITS < bsbm_pkg::TRIALS_W) ? COUNT_BITS
                                                                   : bsbm_pkg::TRIALS_W,
    localparam int MEAN_W     = N_W + bsbm_pkg::PROB_W,
    localparam int VAR_W      = N_W + bsbm_pkg::PQ_W,
    localparam int SD_W       = (VAR_W + 1) / 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [N_W-1:0]                    o_trials,
    output logic [MEAN_W-1:0]                 o_mean,
    output logic [SD_W-1:0]                   o_sd,
    output logic                              o_busy
);
    import bsbm_pkg::*;

    localparam int SQ_W  = 2 * SD_W;
    localparam int REM_W = SD_W + 3;
    localparam int CNT_W = $clog2(SD_W);

    t_cfg_state r_state;
    t_cfg_state n_state;

    logic [N_W-1:0]       r_trials;
    logic [PROB_W-1:0]    r_prob;
    logic [PROB_W-1:0]    w_pclip;
    logic [PROB_W-1:0]    w_qclip;
    logic [2*PROB_W-1:0]  w_pq_full;
    logic [MEAN_W-1:0]    w_mean_full;
    logic [VAR_W-1:0]     w_var_full;
    logic [PQ_W-1:0]      r_pq;
    logic [PQ_W-1:0]      n_pq;
    logic [MEAN_W-1:0]    r_mean;
    logic [MEAN_W-1:0]    n_mean;
    logic [SQ_W-1:0]      r_sh;
    logic [SQ_W-1:0]      n_sh;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     n_rem;
    logic [REM_W-1:0]     w_rem_sh;
    logic [REM_W-1:0]     w_trial;
    logic [SD_W-1:0]      r_root;
    logic [SD_W-1:0]      n_root;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 w_ge;
    logic                 w_root_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trials <= '0;
            r_prob   <= PROB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TRIALS: begin
                    r_trials <= i_cfg_data[N_W-1:0];
                end
                REG_PROBABILITY: begin
                    r_prob <= i_cfg_data[PROB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // probability above one acts as one
    assign w_pclip     = (r_prob > PROB_ONE) ? PROB_ONE : r_prob;
    assign w_qclip     = PROB_ONE - w_pclip;
    assign w_pq_full   = (2*PROB_W)'(w_pclip) * (2*PROB_W)'(w_qclip);
    assign w_mean_full = MEAN_W'(r_trials) * MEAN_W'(w_pclip);
    assign w_var_full  = VAR_W'(r_trials) * VAR_W'(r_pq);

    // one root bit per cycle
    assign w_rem_sh = {r_rem[SD_W:0], r_sh[SQ_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = w_rem_sh >= w_trial;

    assign w_root_phase = (r_state == S_SQRT) || (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PQ;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pq   <= n_pq;
        r_mean <= n_mean;
        r_sh   <= n_sh;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_pq    = r_pq;
        n_mean  = r_mean;
        n_sh    = r_sh;
        n_rem   = r_rem;
        n_root  = r_root;
        n_cnt   = r_cnt;
        o_busy  = r_state != S_IDLE;
        case (r_state)
            S_IDLE: begin
            end
            S_PQ: begin
                n_pq    = w_pq_full[PQ_W-1:0];
                n_mean  = w_mean_full;
                n_state = S_VAR;
            end
            S_VAR: begin
                n_sh    = SQ_W'(w_var_full);
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = CNT_W'(SD_W - 1);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                n_sh   = r_sh << 2;
                n_rem  = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                n_root = {r_root[SD_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // any write restarts the scale computation
        if (i_cfg_we) begin
            n_state = S_PQ;
        end
    end

    assign o_trials = r_trials;
    assign o_mean   = r_mean;
    assign o_sd     = r_root;

    `BSBM_ASSERT_NEXT(a_write_restarts, i_cfg_we, r_state == S_PQ)
    `BSBM_ASSERT_NOW(a_root_remainder_bound, w_root_phase, r_rem <= (REM_W'(r_root) << 1))

endmodule

/* hw/rtl/bsbm_dp.sv */
module bsbm_dp #(
    parameter int  COUNT_BITS = bsbm_pkg::DEF_COUNT_BITS,
    localparam int N_W        = (COUNT_BITS < bsbm_pkg::TRIALS_W) ? COUNT_BITS
                                                                   : bsbm_pkg::TRIALS_W,
    localparam int MEAN_W     = N_W + bsbm_pkg::PROB_W,
    localparam int VAR_W      = N_W + bsbm_pkg::PQ_W,
    localparam int SD_W       = (VAR_W + 1) / 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bsbm_pkg::RAND_W-1:0]     i_random_bits,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bsbm_pkg::SAMPLE_W-1:0]   o_sample,
    input  logic                            i_busy,
    input  logic [N_W-1:0]                  i_trials,
    input  logic [MEAN_W-1:0]               i_mean,
    input  logic [SD_W-1:0]                 i_sd
);
    import bsbm_pkg::*;

    localparam int PROD_W = SD_W + ZMAG_W;
    localparam int DEV_W  = PROD_W - 13;
    localparam int M30_W  = MEAN_W + 14;
    localparam int TOT_W  = ((M30_W > DEV_W) ? M30_W : DEV_W) + 1;
    localparam int RES_W  = TOT_W - 29;

    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;
    logic w_accept;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;

    logic [RAD_W-1:0]  w_rad;
    logic [CMAG_W-1:0] w_cmag;
    logic              w_neg;

    logic [ZMAG_W-1:0] r_zmag;
    logic              r_neg2;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg3;
    logic [PROD_W:0]   w_dev_full;
    logic [DEV_W-1:0]  r_dev;
    logic              r_neg4;
    logic [M30_W-1:0]  w_mean30;
    logic [TOT_W-1:0]  w_mean_ext;
    logic [TOT_W-1:0]  w_dev_ext;
    logic [TOT_W-1:0]  w_sum;
    logic [TOT_W:0]    w_diff;
    logic [TOT_W-1:0]  r_total;
    logic              r_zero;
    logic [TOT_W:0]    w_rnd;
    logic [RES_W-1:0]  w_res;
    logic [N_W-1:0]    w_clamped;
    logic [SAMPLE_W-1:0] r_sample;

    // a stage moves when the next one is empty or moving
    assign w_en6      = !r_ov || !i_out_stall;
    assign w_en5      = !r_v5 || w_en6;
    assign w_en4      = !r_v4 || w_en5;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1 || i_busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    bsbm_rom u_rom (
        .i_clk      (i_clk),
        .i_en       (w_en1),
        .i_rad_addr (i_random_bits[ADDR_W-1:0]),
        .i_ang_addr (i_random_bits[2*ADDR_W-1:ADDR_W]),
        .o_rad      (w_rad),
        .o_cmag     (w_cmag),
        .o_neg      (w_neg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_accept;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
            if (w_en6) begin
                r_ov <= r_v5;
            end
        end
    end

    assign w_dev_full = {1'b0, r_prod} + {{(PROD_W-13){1'b0}}, 1'b1, 13'b0};

    assign w_mean30   = {i_mean, 14'b0};
    assign w_mean_ext = TOT_W'(w_mean30);
    assign w_dev_ext  = TOT_W'(r_dev);
    assign w_sum      = w_mean_ext + w_dev_ext;
    assign w_diff     = {1'b0, w_mean_ext} - {1'b0, w_dev_ext};

    assign w_rnd     = {1'b0, r_total} + {{(TOT_W-29){1'b0}}, 1'b1, 29'b0};
    assign w_res     = w_rnd[TOT_W:30];
    assign w_clamped = r_zero ? '0
                     : (w_res > RES_W'(i_trials)) ? i_trials
                     : w_res[N_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_zmag <= ZMAG_W'(w_rad) * ZMAG_W'(w_cmag);
            r_neg2 <= w_neg;
        end
        if (w_en3) begin
            r_prod <= PROD_W'(i_sd) * PROD_W'(r_zmag);
            r_neg3 <= r_neg2;
        end
        if (w_en4) begin
            r_dev  <= w_dev_full[PROD_W:14];
            r_neg4 <= r_neg3;
        end
        if (w_en5) begin
            // a negative total clamps to zero
            r_total <= r_neg4 ? w_diff[TOT_W-1:0] : w_sum;
            r_zero  <= r_neg4 && w_diff[TOT_W];
        end
        if (w_en6) begin
            r_sample <= SAMPLE_W'(w_clamped);
        end
    end

    assign o_out_valid = r_ov;
    assign o_sample    = r_sample;

endmodule

/* hw/rtl/binomial_sampler_table_box_muller_core.sv */
// Approximate binomial sampler: each 16-bit random word picks a radius from one ROM (low byte)
// and an angle cosine from another (high byte); their product, a standard normal sample, is
// scaled by sqrt(n p (1-p)), offset by n p, rounded half away from zero and clamped to 0..n.
// One item is taken per clock unless the input is stalled; each result passes in order through
// the ROM read register, two multiplier stages, a rounding stage, the mean add and the output
// register. After reset and after every register write the input is stalled while the spread
// sqrt(n p (1-p)) is recomputed by a square-root unit that settles one result bit per clock.
`include "binomial_sampler_table_box_muller_core_macros.svh"

module binomial_sampler_table_box_muller_core #(
    parameter int COUNT_BITS = bsbm_pkg::DEF_COUNT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bsbm_pkg::RAND_W-1:0]     i_random_bits,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bsbm_pkg::SAMPLE_W-1:0]   o_sample,
    input  logic                            i_cfg_we,
    input  logic [bsbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bsbm_pkg::*;

    localparam int N_W    = (COUNT_BITS < TRIALS_W) ? COUNT_BITS : TRIALS_W;
    localparam int MEAN_W = N_W + PROB_W;
    localparam int VAR_W  = N_W + PQ_W;
    localparam int SD_W   = (VAR_W + 1) / 2;

    logic [N_W-1:0]    w_trials;
    logic [MEAN_W-1:0] w_mean;
    logic [SD_W-1:0]   w_sd;
    logic              w_busy;

    bsbm_cfg #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_trials    (w_trials),
        .o_mean      (w_mean),
        .o_sd        (w_sd),
        .o_busy      (w_busy)
    );

    bsbm_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_random_bits (i_random_bits),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample      (o_sample),
        .i_busy        (w_busy),
        .i_trials      (w_trials),
        .i_mean        (w_mean),
        .i_sd          (w_sd)
    );

    `BSBM_ASSERT_NOW(a_sample_within_trials, o_out_valid, o_sample <= SAMPLE_W'(w_trials))

endmodule

/* tb/binomial_sampler_table_box_muller_core_tb.sv */
`timescale 1ns / 1ps

module binomial_sampler_table_box_muller_core_tb;
    import bsbm_pkg::*;

    localparam int              CYCLE_LIMIT = 1000000;
    localparam int              PHASE_ITEMS = 250;
    localparam int              HOLD_CYCLES = 400;
    localparam longint unsigned LN2_FIX     = 64'd2977044472;
    localparam longint unsigned PI_FIX      = 64'd3373259426;
    localparam longint unsigned ANGLE_DIV   = 64'd257;

    typedef enum logic [0:0] {
        ROW_CFG,
        ROW_ITEM
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   has_golden;
        logic [SAMPLE_W-1:0]    golden;
    } t_script_row;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic [RAND_W-1:0]      random_bits = '0;
    logic                   out_stall = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_TRIALS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_stall;
    logic                   out_valid;
    logic [SAMPLE_W-1:0]    sample;

    logic [TRIALS_W-1:0]    trials_cfg = '0;
    logic [PROB_W-1:0]      prob_cfg = PROB_RESET;
    logic [15:0]            radius_q14 [TABLE_ENTRIES];
    logic [14:0]            cos_mag [TABLE_ENTRIES];
    logic                   cos_neg [TABLE_ENTRIES];

    logic [SAMPLE_W-1:0]    pending_samples [$];
    t_script_row            script [$];
    logic [SAMPLE_W-1:0]    want;
    int                     errors = 0;
    int                     cycle_count = 0;
    int                     stall_left = 0;
    bit                     tx_jitter = 1'b0;
    bit                     rx_jitter = 1'b0;
    bit                     rx_hold_req = 1'b0;

    binomial_sampler_table_box_muller_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_random_bits (random_bits),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_sample      (sample),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned acc;
        longint unsigned res;
        longint unsigned b;
        acc = x;
        res = 0;
        b   = 64'd1 << 62;
        while (b > acc) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (acc >= res + b) begin
                acc = acc - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // natural log of an integer, q32
    function automatic longint unsigned ln_fixed(input longint unsigned k);
        longint unsigned m;
        longint unsigned p2;
        longint unsigned z;
        longint unsigned zz;
        longint unsigned t;
        longint unsigned acc;
        int              j;
        m  = 0;
        p2 = 1;
        while (p2 * 64'd2 <= k) begin
            p2 = p2 * 64'd2;
            m  = m + 64'd1;
        end
        z   = ((k - p2) << 32) / (k + p2);
        zz  = (z * z) >> 32;
        t   = z;
        acc = z;
        for (j = 1; j < 16; j++) begin
            t   = (t * zz) >> 32;
            acc = acc + t / 64'(2 * j + 1);
        end
        return m * LN2_FIX + 64'd2 * acc;
    endfunction

    // cos(pi num / 257), q30, clipped at zero
    function automatic longint unsigned cosine_fixed(input longint unsigned num);
        longint unsigned a;
        longint unsigned a2;
        longint unsigned tm;
        longint          acc;
        int              j;
        a   = (PI_FIX * num) / ANGLE_DIV;
        a2  = (a * a) >> 30;
        tm  = 64'd1 << 30;
        acc = longint'(tm);
        for (j = 1; j <= 12; j++) begin
            tm = ((tm * a2) >> 30) / 64'((2 * j - 1) * (2 * j));
            if ((j % 2) == 1) begin
                acc = acc - longint'(tm);
            end else begin
                acc = acc + longint'(tm);
            end
        end
        return (acc < 0) ? 64'd0 : unsigned'(acc);
    endfunction

    task automatic build_tables();
        longint unsigned ln_top;
        longint unsigned k;
        longint unsigned kk;
        longint unsigned v;
        longint unsigned s;
        longint unsigned num;
        longint unsigned c;
        logic            neg;
        ln_top = ln_fixed(ANGLE_DIV);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            k             = 64'(i) + 64'd1;
            v             = 64'd2 * (ln_top - ln_fixed(k));
            s             = floor_sqrt(v << 26);
            radius_q14[i] = 16'((s + (64'd1 << 14)) >> 15);
            kk            = (k <= ANGLE_DIV - k) ? k : ANGLE_DIV - k;
            num           = 64'd2 * kk;
            neg           = 1'b0;
            if (64'd2 * num > ANGLE_DIV) begin
                neg = 1'b1;
                num = ANGLE_DIV - num;
            end
            c          = (cosine_fixed(num) + (64'd1 << 15)) >> 16;
            cos_mag[i] = 15'(c);
            cos_neg[i] = neg && (c != 0);
        end
    endtask

    // mean n p plus sd times the table normal, rounded and clamped to 0..n
    function automatic logic [SAMPLE_W-1:0] binomial_estimate(input logic [RAND_W-1:0] bits);
        longint unsigned n;
        longint unsigned p;
        longint unsigned zmag;
        longint unsigned mean_q30;
        longint unsigned var_q32;
        longint unsigned sd;
        longint unsigned dev;
        longint unsigned total;
        longint unsigned res;
        logic            zneg;
        n        = 64'(trials_cfg);
        p        = (prob_cfg > PROB_ONE) ? 64'd65536 : longint'(prob_cfg);
        zmag     = longint'(radius_q14[bits[7:0]]) * longint'(cos_mag[bits[15:8]]);
        zneg     = cos_neg[bits[15:8]];
        mean_q30 = (n * p) << 14;
        var_q32  = n * (p * (64'd65536 - p));
        sd       = floor_sqrt(var_q32);
        dev      = (sd * zmag + (64'd1 << 13)) >> 14;
        if (zneg && dev > mean_q30) begin
            return '0;
        end
        total = zneg ? mean_q30 - dev : mean_q30 + dev;
        res   = (total + (64'd1 << 29)) >> 30;
        if (res > n) begin
            res = n;
        end
        return res[SAMPLE_W-1:0];
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic add_row(input t_row_kind kind, input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input logic has_golden,
                           input logic [SAMPLE_W-1:0] golden);
        t_script_row row;
        row.kind       = kind;
        row.idx        = idx;
        row.value      = value;
        row.has_golden = has_golden;
        row.golden     = golden;
        script.push_back(row);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TRIALS) begin
            trials_cfg = value[TRIALS_W-1:0];
        end else begin
            prob_cfg = value;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic push_word(input logic [RAND_W-1:0] bits, input logic has_golden,
                             input logic [SAMPLE_W-1:0] golden);
        int gap;
        gap = (tx_jitter && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        random_bits <= bits;
        forever begin
            @(posedge clk);
            if (!in_stall) begin
                break;
            end
        end
        pending_samples.push_back(has_golden ? golden : binomial_estimate(bits));
        @(negedge clk);
    endtask

    // receiver side: random stalls and one long hold-off on request
    always @(negedge clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            stall_left  = HOLD_CYCLES;
        end else if (stall_left == 0 && rx_jitter && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: sample expected none actual %0d", $time, sample);
            end else begin
                want = pending_samples.pop_front();
                if (sample !== want) begin
                    errors++;
                    $display("%0t: sample expected %0d actual %0d", $time, want, sample);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] n_set;
        logic [CFG_DATA_W-1:0] p_set;

        build_tables();

        // kind      index            value       golden?  golden
        add_row(ROW_ITEM, REG_TRIALS,      17'h00000, 1'b1, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h0FFFF, 1'b1, 16'd0);
        add_row(ROW_CFG,  REG_TRIALS,      17'h1FFFF, 1'b0, 16'd0);
        add_row(ROW_CFG,  REG_PROBABILITY, 17'h10000, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h00000, 1'b1, 16'd65535);
        add_row(ROW_ITEM, REG_TRIALS,      17'h08000, 1'b1, 16'd65535);
        add_row(ROW_CFG,  REG_PROBABILITY, 17'h1FFFF, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h01234, 1'b1, 16'd65535);
        add_row(ROW_CFG,  REG_PROBABILITY, 17'h00000, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h00000, 1'b1, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h0FFFF, 1'b1, 16'd0);
        add_row(ROW_CFG,  REG_PROBABILITY, 17'h08000, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h00000, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h08000, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h000FF, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h0FF00, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h080FF, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h07F80, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h05AA5, 1'b0, 16'd0);
        add_row(ROW_CFG,  REG_TRIALS,      17'h00001, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h08000, 1'b1, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h00000, 1'b1, 16'd1);
        add_row(ROW_CFG,  REG_TRIALS,      17'h00000, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h00000, 1'b1, 16'd0);
        add_row(ROW_CFG,  REG_TRIALS,      17'd40000, 1'b0, 16'd0);
        add_row(ROW_CFG,  REG_PROBABILITY, 17'h00001, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h00000, 1'b0, 16'd0);
        add_row(ROW_ITEM, REG_TRIALS,      17'h08000, 1'b0, 16'd0);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                drain();
                cfg_write(script[i].idx, script[i].value);
            end else begin
                push_word(script[i].value[RAND_W-1:0], script[i].has_golden, script[i].golden);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    n_set = 17'd65535;
                    p_set = PROB_RESET;
                end
                1: begin
                    n_set = 17'd65535;
                    p_set = PROB_ONE;
                end
                2: begin
                    n_set = CFG_DATA_W'($urandom_range(0, 65535));
                    p_set = CFG_DATA_W'($urandom_range(0, 65536));
                end
                3: begin
                    n_set = CFG_DATA_W'($urandom_range(1, 40));
                    p_set = CFG_DATA_W'($urandom_range(1, 65535));
                end
                4: begin
                    n_set = CFG_DATA_W'($urandom_range(0, 65535));
                    p_set = CFG_DATA_W'($urandom_range(0, 131071));
                end
                5: begin
                    n_set = CFG_DATA_W'($urandom_range(1, 3));
                    p_set = CFG_DATA_W'($urandom_range(0, 4096));
                end
                6: begin
                    n_set = 17'd0;
                    p_set = CFG_DATA_W'($urandom_range(0, 65536));
                end
                default: begin
                    n_set = CFG_DATA_W'($urandom_range(0, 65535));
                    p_set = ($urandom_range(0, 1) == 1) ? 17'd1 : 17'd65535;
                end
            endcase
            drain();
            cfg_write(REG_TRIALS, n_set);
            cfg_write(REG_PROBABILITY, p_set);
            tx_jitter = (phase != 0) && (phase != 3);
            rx_jitter = (phase != 0);
            // long receiver hold while the sender keeps offering
            if (phase == 3) begin
                rx_hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) push_word(RAND_W'($urandom_range(0, 65535)), 1'b0, '0);
        end

        drain();
        repeat (16) @(posedge clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
